/* hdl/ddlr_pkg.sv */
package ddlr_pkg;

    localparam int unsigned CountWidth = 32;
    localparam int unsigned XWidth     = 9;
    localparam int unsigned HueWidth   = 10;

    localparam logic [1:0] REG_START_OFFSET = 2'd0;
    localparam logic [1:0] REG_DIGIT_PITCH  = 2'd1;
    localparam logic [1:0] REG_HUE_STEP     = 2'd2;

    localparam logic [HueWidth:0]   WheelSpan     = 11'd768;
    localparam logic [HueWidth:0]   WheelSpanTwo  = 11'd1536;
    localparam logic [HueWidth:0]   HueSpacing    = 11'd40;
    localparam logic [3:0]          LastIndex     = 4'd9;
    localparam logic [1:0]          GroupLast     = 2'd2;
    localparam logic [XWidth-1:0]   GroupGap      = 9'd2;
    localparam logic [CountWidth-1:0] RecipTen    = 32'hCCCC_CCCD;
    localparam int unsigned         RecipShift    = 35;

    typedef struct packed {
        logic [5:0]          start_offset;
        logic [4:0]          digit_pitch;
        logic [HueWidth-1:0] hue_step;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

    function automatic logic [15:0] wheel565(input logic [HueWidth-1:0] p);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'd0;
        g = 8'd0;
        b = 8'd0;
        case (p[9:8])
            2'b00:
            begin
                r = ~p[7:0];
                g = p[7:0];
            end
            2'b01:
            begin
                g = ~p[7:0];
                b = p[7:0];
            end
            default:
            begin
                r = p[7:0];
                b = ~p[7:0];
            end
        endcase
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [CountWidth-1:0] div_ten(input logic [CountWidth-1:0] v);
        logic [2*CountWidth-1:0] prod;
        prod = {{CountWidth{1'b0}}, v} * {{CountWidth{1'b0}}, RecipTen};
        return CountWidth'(prod >> RecipShift);
    endfunction

endpackage

/* hdl/ddlr_ctrl.sv */
module ddlr_ctrl
    import ddlr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        StIdle = 3'b001,
        StPrep = 3'b010,
        StRun  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != StIdle);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = StPrep;
                end
            end
            StPrep:
            begin
                cmd.prep   = 1'b1;
                state_next = StRun;
            end
            StRun:
            begin
                if (out_free)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last)
                    begin
                        state_next = StIdle;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/ddlr_datapath.sv */
module ddlr_datapath
    import ddlr_pkg::*;
#(
    parameter int unsigned DISPLAY_WIDTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [CountWidth-1:0]    count_value,
    output logic [3:0]               digit,
    output logic [3:0]               digit_index,
    output logic signed [XWidth-1:0] x_position,
    output logic [15:0]              color565,
    output logic                     last_digit
);

    localparam logic [XWidth-1:0] DisplayWidthX = XWidth'(DISPLAY_WIDTH);

    logic [HueWidth-1:0]   phase_reg;
    logic [HueWidth-1:0]   phase_next;
    logic [HueWidth:0]     phase_sum;
    logic [CountWidth-1:0] n_reg;
    logic [CountWidth-1:0] q_reg;
    logic [CountWidth-1:0] div_in;
    logic [CountWidth-1:0] rem;
    logic [3:0]            idx_reg;
    logic [XWidth-1:0]     xw_reg;
    logic [XWidth-1:0]     xw_next;
    logic [1:0]            group_reg;
    logic [HueWidth-1:0]   hue_reg;
    logic [HueWidth-1:0]   hue_next;
    logic [HueWidth:0]     hue_sum;
    logic                  last;

    logic [3:0]            digit_reg;
    logic [3:0]            digit_index_reg;
    logic [XWidth-1:0]     x_position_reg;
    logic [15:0]           color565_reg;
    logic                  last_digit_reg;

    assign phase_sum = {1'b0, phase_reg} + {1'b0, cfg.hue_step};

    always_comb
    begin
        if (phase_sum >= WheelSpanTwo)
        begin
            phase_next = HueWidth'(phase_sum - WheelSpanTwo);
        end
        else if (phase_sum >= WheelSpan)
        begin
            phase_next = HueWidth'(phase_sum - WheelSpan);
        end
        else
        begin
            phase_next = HueWidth'(phase_sum);
        end
    end

    assign hue_sum  = {1'b0, hue_reg} + HueSpacing;
    assign hue_next = (hue_sum >= WheelSpan) ? HueWidth'(hue_sum - WheelSpan)
                                             : HueWidth'(hue_sum);

    assign div_in = cmd.prep ? n_reg : q_reg;
    assign rem    = n_reg - {q_reg[CountWidth-4:0], 3'b000} - {q_reg[CountWidth-2:0], 1'b0};
    assign last   = (q_reg == '0) || (idx_reg == LastIndex);

    assign xw_next = xw_reg - XWidth'(cfg.digit_pitch)
                     - ((group_reg == GroupLast) ? GroupGap : '0);

    assign status.last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (cmd.load)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg     <= count_value;
            idx_reg   <= '0;
            group_reg <= '0;
            hue_reg   <= phase_next;
            xw_reg    <= DisplayWidthX - XWidth'(cfg.start_offset) - XWidth'(cfg.digit_pitch);
        end
        if (cmd.prep || cmd.step)
        begin
            q_reg <= div_ten(div_in);
        end
        if (cmd.step)
        begin
            n_reg           <= q_reg;
            idx_reg         <= idx_reg + 4'd1;
            group_reg       <= (group_reg == GroupLast) ? 2'd0 : group_reg + 2'd1;
            hue_reg         <= hue_next;
            xw_reg          <= xw_next;
            digit_reg       <= rem[3:0];
            digit_index_reg <= idx_reg;
            x_position_reg  <= xw_reg;
            color565_reg    <= wheel565(hue_reg);
            last_digit_reg  <= last;
        end
    end

    assign digit       = digit_reg;
    assign digit_index = digit_index_reg;
    assign x_position  = signed'(x_position_reg);
    assign color565    = color565_reg;
    assign last_digit  = last_digit_reg;

endmodule

/* hdl/decimal_digit_layout_rainbow_top.sv */
// Decimal digit emitter with a color wheel.
//
// Input channel: one 32-bit count_value per transfer (in_valid, in_stall).
// Output channel: one transfer per decimal digit, least significant first,
// at least one; last_digit marks the most significant digit of a count.
// Each output carries the digit, its index, the signed left x position of
// the glyph and an RGB565 color from the hue wheel.
// On each accepted count the hue phase advances by hue_step modulo 768.
// After the input transfer the control steps through Prep and then Run, where
// the first digit is loaded into the output register; later digits follow
// one per cycle while out_stall is low. The rate is set by the one
// divide-by-ten multiplier, used once in Prep and once per digit.
// in_stall stays high until the last digit is loaded into the output
// register; the next count is taken while that digit waits to transfer.
// A stalled output holds its value and pauses digit generation.
// Reset clears the hue phase, the control state and the output valid, and
// loads start_offset 2, digit_pitch 6 and hue_step 8.
// Registers: start_offset at 0x0, digit_pitch at 0x4, hue_step at 0x8.
module decimal_digit_layout_rainbow_top
    import ddlr_pkg::*;
#(
    parameter int unsigned DISPLAY_WIDTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CountWidth-1:0]    count_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [3:0]               digit,
    output logic [3:0]               digit_index,
    output logic signed [XWidth-1:0] x_position,
    output logic [15:0]              color565,
    output logic                     last_digit
);

    logic [5:0]          start_offset_reg;
    logic [4:0]          digit_pitch_reg;
    logic [HueWidth-1:0] hue_step_reg;
    logic                cfg_wr;
    cfg_t                cfg;
    dp_cmd_t             cmd;
    dp_status_t          status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= 6'd2;
            digit_pitch_reg  <= 5'd6;
            hue_step_reg     <= 10'd8;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_START_OFFSET: start_offset_reg <= pwdata[5:0];
                REG_DIGIT_PITCH:  digit_pitch_reg  <= pwdata[4:0];
                REG_HUE_STEP:     hue_step_reg     <= pwdata[HueWidth-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_START_OFFSET: prdata = 32'(start_offset_reg);
            REG_DIGIT_PITCH:  prdata = 32'(digit_pitch_reg);
            REG_HUE_STEP:     prdata = 32'(hue_step_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.start_offset = start_offset_reg;
    assign cfg.digit_pitch  = digit_pitch_reg;
    assign cfg.hue_step     = hue_step_reg;

    ddlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ddlr_datapath #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .count_value (count_value),
        .digit       (digit),
        .digit_index (digit_index),
        .x_position  (x_position),
        .color565    (color565),
        .last_digit  (last_digit)
    );

endmodule

/* hdl/ddlr_checker.sv */
module ddlr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] digit,
    input logic [3:0] digit_index,
    input logic       last_digit
);

    // The block is busy in the cycle after taking a count.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("in_stall low right after an input transfer");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit <= 4'd9)
        else $error("digit above nine");

    a_tenth_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_index == 4'd9 |-> last_digit)
        else $error("tenth digit not marked last");

    // A digit that is not the last is followed by the next index.
    a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_digit && digit_index != 4'd9 |=>
            !out_valid || digit_index == $past(digit_index) + 4'd1)
        else $error("digit index did not advance");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digit))
        else $error("stalled output changed");

endmodule

bind decimal_digit_layout_rainbow_top ddlr_checker u_ddlr_checker (.*);

/* test/digit_stream_checker.sv */
`timescale 1ns / 1ps

module digit_stream_checker
    import ddlr_pkg::*;
#(
    parameter int unsigned DISPLAY_WIDTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [CountWidth-1:0]    count_value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [3:0]               digit,
    input  logic [3:0]               digit_index,
    input  logic signed [XWidth-1:0] x_position,
    input  logic [15:0]              color565,
    input  logic                     last_digit,
    output int                       fail_count,
    output int                       pending,
    output int                       digits_checked
);

    localparam int unsigned HueWrap      = 768;
    localparam int unsigned HueGap       = 40;
    localparam int unsigned MaxDigits    = 10;
    localparam int unsigned GroupSize    = 3;
    localparam int unsigned GroupShift   = 2;
    localparam int unsigned ReportLimit  = 10;
    localparam logic [5:0]  OffsetReset  = 6'd2;
    localparam logic [4:0]  PitchReset   = 5'd6;
    localparam logic [9:0]  StepReset    = 10'd8;

    typedef struct packed {
        logic [3:0]        digit;
        logic [3:0]        index;
        logic [XWidth-1:0] x;
        logic [15:0]       color;
        logic              last;
    } glyph_t;

    cfg_t        layout;
    int unsigned hue_phase;
    glyph_t      digits_due[$];
    glyph_t      seen;
    glyph_t      wanted;
    int          mismatches;
    int          checked;

    function automatic logic [15:0] wheel_rgb565(input int unsigned pos);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        int unsigned q;
        q = pos % HueWrap;
        if (q < 256)
        begin
            r = 8'(255 - q);
            g = 8'(q);
            b = 8'd0;
        end
        else if (q < 512)
        begin
            q = q - 256;
            r = 8'd0;
            g = 8'(255 - q);
            b = 8'(q);
        end
        else
        begin
            q = q - 512;
            r = 8'(q);
            g = 8'd0;
            b = 8'(255 - q);
        end
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Advances the hue and queues one glyph per decimal digit of the count.
    function automatic void expand_count(input logic [CountWidth-1:0] value);
        logic [CountWidth-1:0] rest;
        logic [XWidth-1:0]     xpos;
        int unsigned           idx;
        int unsigned           grp;
        glyph_t                g;
        rest = value;
        xpos = XWidth'(DISPLAY_WIDTH) - XWidth'(layout.start_offset)
               - XWidth'(layout.digit_pitch);
        idx = 0;
        grp = 0;
        hue_phase = (hue_phase + layout.hue_step) % HueWrap;
        do
        begin
            g.digit = 4'(rest % 10);
            rest = rest / 10;
            g.index = 4'(idx);
            g.x = xpos;
            g.color = wheel_rgb565(hue_phase + HueGap * idx);
            g.last = (rest == 0);
            digits_due = {digits_due, g};
            xpos = xpos - XWidth'(layout.digit_pitch);
            grp++;
            if (grp == GroupSize)
            begin
                xpos = xpos - XWidth'(GroupShift);
                grp = 0;
            end
            idx++;
        end
        while (rest != 0 && idx < MaxDigits);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout.start_offset = OffsetReset;
            layout.digit_pitch = PitchReset;
            layout.hue_step = StepReset;
            hue_phase = 0;
            digits_due.delete();
            mismatches = 0;
            checked = 0;
            fail_count <= 0;
            pending <= 0;
            digits_checked <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_START_OFFSET: layout.start_offset = pwdata[5:0];
                    REG_DIGIT_PITCH:  layout.digit_pitch = pwdata[4:0];
                    REG_HUE_STEP:     layout.hue_step = pwdata[9:0];
                    default:          ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen = '{digit, digit_index, x_position, color565, last_digit};
                if (digits_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= ReportLimit)
                        $display("%0t: digit with nothing outstanding: digit %0d index %0d",
                                 $realtime, digit, digit_index);
                end
                else
                begin
                    wanted = digits_due.pop_front();
                    checked++;
                    if (seen !== wanted)
                    begin
                        mismatches++;
                        if (mismatches <= ReportLimit)
                        begin
                            $display("%0t: wanted digit %0d index %0d x %0d color %h last %b",
                                     $realtime, wanted.digit, wanted.index,
                                     $signed(wanted.x), wanted.color, wanted.last);
                            $display("%0t:    got digit %0d index %0d x %0d color %h last %b",
                                     $realtime, seen.digit, seen.index,
                                     $signed(seen.x), seen.color, seen.last);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                expand_count(count_value);
            fail_count <= mismatches;
            pending <= digits_due.size();
            digits_checked <= checked;
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb
    import ddlr_pkg::*;
();

    localparam int unsigned DisplayWidth = 64;
    localparam logic [1:0]  RegSpare     = 2'd3;
    localparam int unsigned RandomPhases = 8;
    localparam int unsigned PhaseItems   = 31;
    localparam int unsigned MaxIdle      = 10;
    localparam int unsigned DrainLimit   = 20000;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [3:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic [CountWidth-1:0]    count_value;
    logic                     out_valid;
    logic                     out_stall;
    logic [3:0]               digit;
    logic [3:0]               digit_index;
    logic signed [XWidth-1:0] x_position;
    logic [15:0]              color565;
    logic                     last_digit;

    int fail_count;
    int pending;
    int digits_checked;
    int counts_sent;
    int settings_used;
    bit calm;

    decimal_digit_layout_rainbow_top #(.DISPLAY_WIDTH(DisplayWidth)) uut (.*);

    digit_stream_checker #(.DISPLAY_WIDTH(DisplayWidth)) digit_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int unsigned hold;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, MaxIdle);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Unused register bits carry random data so that every bus bit toggles.
    task automatic set_layout(input logic [5:0] offset, input logic [4:0] pitch,
                              input logic [9:0] step, input bit poke_spare);
        write_reg(REG_START_OFFSET, {$urandom} & ~32'h3F | 32'(offset));
        write_reg(REG_DIGIT_PITCH, {$urandom} & ~32'h1F | 32'(pitch));
        write_reg(REG_HUE_STEP, {$urandom} & ~32'h3FF | 32'(step));
        if (poke_spare)
            write_reg(RegSpare, $urandom);
        settings_used++;
    endtask

    task automatic send_count(input logic [CountWidth-1:0] value);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MaxIdle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        count_value <= value;
        do @(posedge clk); while (in_stall);
        counts_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CountWidth-1:0] random_count();
        int unsigned width;
        longint      lo;
        longint      hi;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        width = $urandom_range(1, 10);
        lo = 1;
        repeat (width - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (width == 1)
            lo = 0;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        return $urandom_range(32'(hi), 32'(lo));
    endfunction

    initial
    begin
        logic [CountWidth-1:0] opening[$];
        int unsigned           cycles;
        opening = '{0, 1, 9, 10, 99, 100, 999, 1000, 12345, 999999999, 1000000000,
                    32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        counts_sent = 0;
        settings_used = 0;
        calm = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        count_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_count(opening[i]);
        drain();

        set_layout(6'd63, 5'd16, 10'd767, 1'b0);
        send_count(32'hFFFF_FFFF);
        send_count(0);
        drain();
        set_layout(6'd0, 5'd0, 10'd1023, 1'b0);
        send_count(32'hFFFF_FFFF);
        send_count(7);
        drain();
        set_layout(6'd0, 5'd31, 10'd768, 1'b1);
        send_count(1234567890);
        send_count(9);
        drain();

        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            calm = (phase % 3 == 1);
            set_layout(6'($urandom_range(0, 63)),
                       ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 16)),
                       10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
            repeat (PhaseItems) send_count(random_count());
            drain();
        end

        calm = 1'b0;
        in_valid <= 1'b0;
        cycles = 0;
        while (pending != 0 && cycles < DrainLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d counts under %0d register settings plus the reset layout.",
                 counts_sent, settings_used);
        $display("Checked %0d digit transfers; %0d still outstanding.",
                 digits_checked, pending);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
